### hw/rtl/zsn_pkg.sv
package zsn_pkg;

    localparam int DEF_MAX_DIMS     = 8;
    localparam int DEF_MAX_ELEMENTS = 8192;

    localparam int STEP_W     = 8;
    localparam int ND_W       = 8;
    localparam int CFG_DATA_W = 4;
    localparam int NUM_W      = 30;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_READ = 1'b1;

    localparam logic CFG_NUM_DIMS      = 1'b0;
    localparam logic CFG_ENABLE_WHITEN = 1'b1;

    localparam logic [3:0] NUM_DIMS_RST = 4'd2;

    typedef struct packed {
        logic              cmd;
        logic signed [15:0] sample_value;
        logic              last_sample;
    } sample_t;

    typedef struct packed {
        logic signed [15:0] norm_value;
        logic              zero_spread;
        logic              last_out;
    } result_t;

    typedef enum logic [1:0] {
        OP_MUL  = 2'd0,
        OP_DIV  = 2'd1,
        OP_SQRT = 2'd2
    } unit_op_t;

    typedef struct packed {
        logic              start;
        unit_op_t          op;
        logic [STEP_W-1:0] steps;
    } ucmd_t;

endpackage

### hw/rtl/zsn_store.sv
module zsn_store
    import zsn_pkg::*;
#(
    parameter int DEPTH = DEF_MAX_ELEMENTS,
    parameter int AW    = $clog2(DEF_MAX_ELEMENTS)
)
(
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [15:0]   wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [15:0]   rdata
);

    logic [15:0] mem [DEPTH];
    logic [15:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### hw/rtl/zsn_unit.sv
module zsn_unit
    import zsn_pkg::*;
#(
    parameter int DW = 59
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  ucmd_t         cmd,
    input  logic [DW-1:0] a,
    input  logic [DW-1:0] b,
    output logic          done,
    output logic [DW-1:0] q,
    output logic [DW-1:0] r
);

    localparam int RW = DW + 2;
    localparam int EW = DW + 1;

    unit_op_t          op_reg;
    logic [STEP_W-1:0] idx_reg;
    logic [EW-1:0]     a_reg;
    logic [DW-1:0]     b_reg;
    logic [RW-1:0]     acc_reg;
    logic [DW-1:0]     q_reg;
    logic              busy_reg;
    logic              done_reg;

    logic [STEP_W:0] pos;
    logic [EW-1:0]   a_sh;
    logic [DW-1:0]   b_sh;
    logic [RW-1:0]   t;
    logic [RW-1:0]   rhs;
    logic [RW:0]     diff;
    logic            ge;
    logic [DW-1:0]   mul_acc;

    always_comb
    begin
        pos     = (op_reg == OP_SQRT) ? {idx_reg, 1'b0} : {1'b0, idx_reg};
        a_sh    = a_reg >> pos;
        b_sh    = b_reg >> idx_reg;
        t       = (op_reg == OP_SQRT) ? {acc_reg[RW-3:0], a_sh[1:0]}
                                      : {acc_reg[RW-2:0], a_sh[0]};
        rhs     = (op_reg == OP_SQRT) ? {q_reg, 2'b01} : {2'b00, b_reg};
        diff    = {1'b0, t} - {1'b0, rhs};
        ge      = !diff[RW];
        mul_acc = {acc_reg[DW-2:0], 1'b0} + (b_sh[0] ? a_reg[DW-1:0] : '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            op_reg   <= OP_MUL;
        end
        else
        begin
            done_reg <= !cmd.start && busy_reg && (idx_reg == '0);
            if (cmd.start)
            begin
                op_reg   <= cmd.op;
                idx_reg  <= cmd.steps - 1'b1;
                a_reg    <= {1'b0, a};
                b_reg    <= b;
                acc_reg  <= '0;
                q_reg    <= '0;
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                unique case (op_reg)
                    OP_MUL:
                    begin
                        acc_reg <= {2'b00, mul_acc};
                    end
                    OP_DIV, OP_SQRT:
                    begin
                        if (ge)
                        begin
                            acc_reg <= diff[RW-1:0];
                            q_reg   <= {q_reg[DW-2:0], 1'b1};
                        end
                        else
                        begin
                            acc_reg <= t;
                            q_reg   <= {q_reg[DW-2:0], 1'b0};
                        end
                    end
                    default:
                    begin
                        acc_reg <= acc_reg;
                    end
                endcase
                idx_reg <= idx_reg - 1'b1;
                if (idx_reg == '0)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    assign done = done_reg;
    assign q    = (op_reg == OP_MUL) ? acc_reg[DW-1:0] : q_reg;
    assign r    = acc_reg[DW-1:0];

endmodule

### hw/rtl/z_score_normalizer.sv
// Channel   Beat                              Handshake
// sample    sample_t {cmd, value, last}       sample_valid / sample_stall
// result    result_t {norm, zero, last}       result_valid / result_stall
// cfg       cfg_index, cfg_data               cfg_valid / cfg_ready (always 1)
//
// One command at a time; multiplies, divides and square roots go through one shift-add/subtract unit.
// Load: the next sample waits for the dim-index divide (CW = bits of element count) of the last one.
// Read: a dim-index divide, plus a 30-bit divide when whitening a nonzero deviation.
// Last load adds statistics: per dimension, three multiplies, a variance divide, a square root and a mean divide.
// Async active-low reset clears control and statistics; the sample store is not cleared.
// A pending result stalls only the final step of the next read.
module z_score_normalizer
    import zsn_pkg::*;
#(
    parameter int MAX_DIMS     = DEF_MAX_DIMS,
    parameter int MAX_ELEMENTS = DEF_MAX_ELEMENTS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  sample_valid,
    output logic                  sample_stall,
    input  sample_t               sample,
    output logic                  result_valid,
    input  logic                  result_stall,
    output result_t               result,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic                  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int CW    = $clog2(MAX_ELEMENTS + 1);
    localparam int AW    = $clog2(MAX_ELEMENTS);
    localparam int DIMW  = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
    localparam int SUM_W = CW + 16;
    localparam int SQ_W  = CW + 31;
    localparam int DW    = CW + SQ_W;

    typedef enum logic [13:0] {
        S_IDLE    = 14'b00000000000001,
        S_LOAD    = 14'b00000000000010,
        S_LD_DIV  = 14'b00000000000100,
        S_ST_CNT  = 14'b00000000001000,
        S_ST_DIM  = 14'b00000000010000,
        S_ST_M1   = 14'b00000000100000,
        S_ST_M2   = 14'b00000001000000,
        S_ST_M3   = 14'b00000010000000,
        S_ST_VAR  = 14'b00000100000000,
        S_ST_SQRT = 14'b00001000000000,
        S_ST_MEAN = 14'b00010000000000,
        S_RD_DIV  = 14'b00100000000000,
        S_RD_NORM = 14'b01000000000000,
        S_RD_OUT  = 14'b10000000000000
    } state_t;

    state_t state_reg;

    logic [3:0]              num_dims_reg;
    logic                    whiten_reg;
    sample_t                 item_reg;
    logic [CW-1:0]           count_reg;
    logic [CW-1:0]           rp_reg;
    logic                    ready_reg;
    logic signed [SUM_W-1:0] sum_reg  [MAX_DIMS];
    logic [SQ_W-1:0]         sq_reg   [MAX_DIMS];
    logic signed [15:0]      mean_reg [MAX_DIMS];
    logic [15:0]             dev_reg  [MAX_DIMS];
    logic [DIMW-1:0]         sd_reg;
    logic [CW-1:0]           n_reg;
    logic [CW-1:0]           cq_reg;
    logic [ND_W-1:0]         cr_reg;
    logic [DW-1:0]           tmp_reg;
    logic                    neg_reg;
    logic signed [15:0]      res_val_reg;
    logic                    res_zero_reg;
    logic                    result_valid_reg;
    result_t                 result_reg;

    ucmd_t         ucmd_reg;
    logic [DW-1:0] ua_reg;
    logic [DW-1:0] ub_reg;
    logic          u_done;
    logic [DW-1:0] u_q;
    logic [DW-1:0] u_r;

    logic               accept;
    logic               out_free;
    logic [ND_W-1:0]    nd;
    logic [CW-1:0]      n_now;
    logic [SUM_W-1:0]   smag;
    logic [DIMW-1:0]    ld_dim;
    logic signed [31:0] xsq;
    logic               mem_we;
    logic               mem_re;
    logic [15:0]        mem_rdata;
    logic signed [15:0] x_rd;
    logic signed [16:0] dnum;
    logic [16:0]        dmag;
    logic [NUM_W-1:0]   numer;
    logic [DW-1:0]      droot;
    logic [15:0]        dev_rnd;

    assign accept       = sample_valid && !sample_stall;
    assign sample_stall = (state_reg != S_IDLE);
    assign out_free     = !result_valid_reg || !result_stall;
    assign cfg_ready    = 1'b1;

    always_comb
    begin
        if (num_dims_reg == 4'd0)
        begin
            nd = ND_W'(1);
        end
        else if (ND_W'(num_dims_reg) > ND_W'(MAX_DIMS))
        begin
            nd = ND_W'(MAX_DIMS);
        end
        else
        begin
            nd = ND_W'(num_dims_reg);
        end
        n_now  = (ND_W'(sd_reg) < nd) ? cq_reg + CW'(cr_reg > ND_W'(sd_reg)) : '0;
        smag   = sum_reg[sd_reg][SUM_W-1] ? SUM_W'(-sum_reg[sd_reg]) : SUM_W'(sum_reg[sd_reg]);
        ld_dim = u_r[DIMW-1:0];
        xsq    = item_reg.sample_value * item_reg.sample_value;
        x_rd   = mem_rdata;
        dnum   = {x_rd[15], x_rd} - {mean_reg[ld_dim][15], mean_reg[ld_dim]};
        dmag   = dnum[16] ? 17'(-dnum) : 17'(dnum);
        numer  = {1'b0, dmag, 12'b0} + NUM_W'(dev_reg[ld_dim] >> 1);
        droot  = u_q + DW'(u_r > u_q);
        dev_rnd = (droot > DW'(16'hFFFF)) ? 16'hFFFF : droot[15:0];
    end

    assign mem_we = (state_reg == S_LD_DIV) && u_done;
    assign mem_re = accept && (sample.cmd == CMD_READ) && ready_reg && (rp_reg < count_reg);

    zsn_store #(
        .DEPTH (MAX_ELEMENTS),
        .AW    (AW)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (count_reg[AW-1:0]),
        .wdata (item_reg.sample_value),
        .re    (mem_re),
        .raddr (rp_reg[AW-1:0]),
        .rdata (mem_rdata)
    );

    zsn_unit #(
        .DW (DW)
    ) u_unit (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (ucmd_reg),
        .a     (ua_reg),
        .b     (ub_reg),
        .done  (u_done),
        .q     (u_q),
        .r     (u_r)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            num_dims_reg     <= NUM_DIMS_RST;
            whiten_reg       <= 1'b1;
            count_reg        <= '0;
            rp_reg           <= '0;
            ready_reg        <= 1'b0;
            sd_reg           <= '0;
            result_valid_reg <= 1'b0;
            ucmd_reg         <= '0;
            for (int i = 0; i < MAX_DIMS; i++)
            begin
                sum_reg[i]  <= '0;
                sq_reg[i]   <= '0;
                mean_reg[i] <= '0;
                dev_reg[i]  <= '0;
            end
        end
        else
        begin
            if (ucmd_reg.start)
            begin
                ucmd_reg.start <= 1'b0;
            end
            if (result_valid_reg && !result_stall && state_reg != S_RD_OUT)
            begin
                result_valid_reg <= 1'b0;
            end
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    CFG_NUM_DIMS:      num_dims_reg <= cfg_data;
                    CFG_ENABLE_WHITEN: whiten_reg   <= cfg_data[0];
                    default:           whiten_reg   <= whiten_reg;
                endcase
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        item_reg <= sample;
                        if (sample.cmd == CMD_LOAD)
                        begin
                            if (ready_reg)
                            begin
                                count_reg <= '0;
                                rp_reg    <= '0;
                                ready_reg <= 1'b0;
                                for (int i = 0; i < MAX_DIMS; i++)
                                begin
                                    sum_reg[i]  <= '0;
                                    sq_reg[i]   <= '0;
                                    mean_reg[i] <= '0;
                                    dev_reg[i]  <= '0;
                                end
                            end
                            state_reg <= S_LOAD;
                        end
                        else if (mem_re)
                        begin
                            ucmd_reg  <= '{1'b1, OP_DIV, STEP_W'(CW)};
                            ua_reg    <= DW'(rp_reg);
                            ub_reg    <= DW'(nd);
                            state_reg <= S_RD_DIV;
                        end
                    end
                end

                S_LOAD:
                begin
                    if (count_reg < CW'(MAX_ELEMENTS))
                    begin
                        ucmd_reg  <= '{1'b1, OP_DIV, STEP_W'(CW)};
                        ua_reg    <= DW'(count_reg);
                        ub_reg    <= DW'(nd);
                        state_reg <= S_LD_DIV;
                    end
                    else if (item_reg.last_sample)
                    begin
                        ucmd_reg  <= '{1'b1, OP_DIV, STEP_W'(CW)};
                        ua_reg    <= DW'(count_reg);
                        ub_reg    <= DW'(nd);
                        state_reg <= S_ST_CNT;
                    end
                    else
                    begin
                        state_reg <= S_IDLE;
                    end
                end

                S_LD_DIV:
                begin
                    if (u_done)
                    begin
                        sum_reg[ld_dim] <= sum_reg[ld_dim] + SUM_W'(item_reg.sample_value);
                        sq_reg[ld_dim]  <= sq_reg[ld_dim] + SQ_W'($unsigned(xsq));
                        count_reg       <= count_reg + 1'b1;
                        if (item_reg.last_sample)
                        begin
                            ucmd_reg  <= '{1'b1, OP_DIV, STEP_W'(CW)};
                            ua_reg    <= DW'(count_reg + 1'b1);
                            ub_reg    <= DW'(nd);
                            state_reg <= S_ST_CNT;
                        end
                        else
                        begin
                            state_reg <= S_IDLE;
                        end
                    end
                end

                S_ST_CNT:
                begin
                    if (u_done)
                    begin
                        cq_reg    <= u_q[CW-1:0];
                        cr_reg    <= u_r[ND_W-1:0];
                        sd_reg    <= '0;
                        state_reg <= S_ST_DIM;
                    end
                end

                S_ST_DIM:
                begin
                    if (n_now == '0)
                    begin
                        mean_reg[sd_reg] <= '0;
                        dev_reg[sd_reg]  <= '0;
                        if (sd_reg == DIMW'(MAX_DIMS - 1))
                        begin
                            ready_reg <= 1'b1;
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            sd_reg <= sd_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        n_reg     <= n_now;
                        ucmd_reg  <= '{1'b1, OP_MUL, STEP_W'(CW)};
                        ua_reg    <= DW'(sq_reg[sd_reg]);
                        ub_reg    <= DW'(n_now);
                        state_reg <= S_ST_M1;
                    end
                end

                S_ST_M1:
                begin
                    if (u_done)
                    begin
                        tmp_reg   <= u_q;
                        ucmd_reg  <= '{1'b1, OP_MUL, STEP_W'(SUM_W)};
                        ua_reg    <= DW'(smag);
                        ub_reg    <= DW'(smag);
                        state_reg <= S_ST_M2;
                    end
                end

                S_ST_M2:
                begin
                    if (u_done)
                    begin
                        tmp_reg   <= (tmp_reg > u_q) ? tmp_reg - u_q : '0;
                        ucmd_reg  <= '{1'b1, OP_MUL, STEP_W'(CW)};
                        ua_reg    <= DW'(n_reg);
                        ub_reg    <= DW'(n_reg);
                        state_reg <= S_ST_M3;
                    end
                end

                S_ST_M3:
                begin
                    if (u_done)
                    begin
                        ucmd_reg  <= '{1'b1, OP_DIV, STEP_W'(DW)};
                        ua_reg    <= tmp_reg;
                        ub_reg    <= u_q;
                        state_reg <= S_ST_VAR;
                    end
                end

                S_ST_VAR:
                begin
                    if (u_done)
                    begin
                        ucmd_reg  <= '{1'b1, OP_SQRT, STEP_W'((DW + 1) / 2)};
                        ua_reg    <= u_q;
                        state_reg <= S_ST_SQRT;
                    end
                end

                S_ST_SQRT:
                begin
                    if (u_done)
                    begin
                        dev_reg[sd_reg] <= dev_rnd;
                        ucmd_reg        <= '{1'b1, OP_DIV, STEP_W'(SUM_W + 1)};
                        ua_reg          <= DW'(smag) + DW'(n_reg >> 1);
                        ub_reg          <= DW'(n_reg);
                        state_reg       <= S_ST_MEAN;
                    end
                end

                S_ST_MEAN:
                begin
                    if (u_done)
                    begin
                        mean_reg[sd_reg] <= sum_reg[sd_reg][SUM_W-1] ? 16'(-u_q[16:0])
                                                                       : u_q[15:0];
                        if (sd_reg == DIMW'(MAX_DIMS - 1))
                        begin
                            ready_reg <= 1'b1;
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            sd_reg    <= sd_reg + 1'b1;
                            state_reg <= S_ST_DIM;
                        end
                    end
                end

                S_RD_DIV:
                begin
                    if (u_done)
                    begin
                        if (!whiten_reg)
                        begin
                            res_val_reg  <= x_rd;
                            res_zero_reg <= 1'b0;
                            state_reg    <= S_RD_OUT;
                        end
                        else if (dev_reg[ld_dim] == '0)
                        begin
                            res_val_reg  <= '0;
                            res_zero_reg <= 1'b1;
                            state_reg    <= S_RD_OUT;
                        end
                        else
                        begin
                            neg_reg      <= dnum[16];
                            res_zero_reg <= 1'b0;
                            ucmd_reg     <= '{1'b1, OP_DIV, STEP_W'(NUM_W)};
                            ua_reg       <= DW'(numer);
                            ub_reg       <= DW'(dev_reg[ld_dim]);
                            state_reg    <= S_RD_NORM;
                        end
                    end
                end

                S_RD_NORM:
                begin
                    if (u_done)
                    begin
                        if (neg_reg)
                        begin
                            res_val_reg <= (u_q > DW'(32768)) ? 16'sh8000 : 16'(-u_q[16:0]);
                        end
                        else
                        begin
                            res_val_reg <= (u_q > DW'(32767)) ? 16'sh7FFF : u_q[15:0];
                        end
                        state_reg <= S_RD_OUT;
                    end
                end

                S_RD_OUT:
                begin
                    if (out_free)
                    begin
                        result_reg.norm_value  <= res_val_reg;
                        result_reg.zero_spread <= res_zero_reg;
                        result_reg.last_out    <= (rp_reg + 1'b1 == count_reg);
                        result_valid_reg       <= 1'b1;
                        rp_reg                 <= rp_reg + 1'b1;
                        state_reg              <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

### dv/z_score_normalizer_tb.sv
`timescale 1ns / 100ps

module z_score_normalizer_tb
    import zsn_pkg::*;
();

    localparam int STORE_DEPTH = DEF_MAX_ELEMENTS;
    localparam int DIM_LIMIT   = DEF_MAX_DIMS;

    class zscore_scoreboard;
        logic [15:0]    sample_mem [STORE_DEPTH];
        longint         sum_by_dim [DIM_LIMIT];
        longint         sq_by_dim [DIM_LIMIT];
        longint         mean_by_dim [DIM_LIMIT];
        longint         dev_by_dim [DIM_LIMIT];
        int             loaded;
        int             read_idx;
        bit             stats_valid;
        int             dims_reg;
        bit             whiten_reg;
        result_t        expected_results [$];
        int             mismatches;

        function new();
            dims_reg   = int'(NUM_DIMS_RST);
            whiten_reg = 1'b1;
            mismatches = 0;
            clear_set();
        endfunction

        function void clear_set();
            for (int d = 0; d < DIM_LIMIT; d++)
            begin
                sum_by_dim[d]  = 0;
                sq_by_dim[d]   = 0;
                mean_by_dim[d] = 0;
                dev_by_dim[d]  = 0;
            end
            loaded      = 0;
            read_idx    = 0;
            stats_valid = 0;
        endfunction

        function void write_reg(logic idx, logic [CFG_DATA_W-1:0] data);
            if (idx == CFG_NUM_DIMS)
                dims_reg = int'(data);
            else
                whiten_reg = data[0];
        endfunction

        function int active_dims();
            if (dims_reg == 0)
                return 1;
            if (dims_reg > DIM_LIMIT)
                return DIM_LIMIT;
            return dims_reg;
        endfunction

        function longint round_div(longint num, longint den);
            longint mag;
            longint q;
            mag = (num < 0) ? -num : num;
            q = (mag + den / 2) / den;
            return (num < 0) ? -q : q;
        endfunction

        function longint int_sqrt(longint unsigned v);
            longint unsigned r;
            longint unsigned b;
            r = 0;
            b = 64'd1 << 62;
            while (b > v)
                b = b >> 2;
            while (b != 0)
            begin
                if (v >= r + b)
                begin
                    v = v - (r + b);
                    r = (r >> 1) + b;
                end
                else
                    r = r >> 1;
                b = b >> 2;
            end
            return r;
        endfunction

        function void update_stats();
            int nd;
            longint unsigned n;
            longint unsigned smag;
            longint unsigned a;
            longint unsigned b;
            longint unsigned var_q;
            longint unsigned r;
            nd = active_dims();
            for (int d = 0; d < DIM_LIMIT; d++)
            begin
                n = 0;
                mean_by_dim[d] = 0;
                dev_by_dim[d]  = 0;
                if (d < nd)
                    n = loaded / nd + (((loaded % nd) > d) ? 1 : 0);
                if (n != 0)
                begin
                    smag  = (sum_by_dim[d] < 0) ? -sum_by_dim[d] : sum_by_dim[d];
                    a     = n * longint'(sq_by_dim[d]);
                    b     = smag * smag;
                    var_q = (a > b) ? (a - b) / (n * n) : 0;
                    r     = int_sqrt(var_q);
                    if (var_q - r * r > r)
                        r++;
                    if (r > 65535)
                        r = 65535;
                    mean_by_dim[d] = round_div(sum_by_dim[d], n);
                    dev_by_dim[d]  = r;
                end
            end
            stats_valid = 1;
        endfunction

        function void note_sample(sample_t s);
            int nd;
            int d;
            longint x;
            longint v;
            result_t r;
            nd = active_dims();
            if (s.cmd == CMD_LOAD)
            begin
                if (stats_valid)
                    clear_set();
                if (loaded < STORE_DEPTH)
                begin
                    x = s.sample_value;
                    d = loaded % nd;
                    sample_mem[loaded] = s.sample_value;
                    sum_by_dim[d] += x;
                    sq_by_dim[d]  += x * x;
                    loaded++;
                end
                if (s.last_sample)
                    update_stats();
                return;
            end
            if (!stats_valid || read_idx >= loaded)
                return;
            d = read_idx % nd;
            x = $signed(sample_mem[read_idx]);
            v = x;
            r.zero_spread = 1'b0;
            if (whiten_reg)
            begin
                if (dev_by_dim[d] == 0)
                begin
                    v = 0;
                    r.zero_spread = 1'b1;
                end
                else
                begin
                    v = round_div((x - mean_by_dim[d]) * 4096, dev_by_dim[d]);
                    if (v > 32767)
                        v = 32767;
                    if (v < -32768)
                        v = -32768;
                end
            end
            r.norm_value = v[15:0];
            r.last_out   = (read_idx + 1 == loaded);
            read_idx++;
            expected_results.insert(expected_results.size(), r);
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (expected_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat: norm %0d zero %0b last %0b",
                             got.norm_value, got.zero_spread, got.last_out);
                return;
            end
            want = expected_results.pop_front();
            if (got.norm_value !== want.norm_value || got.zero_spread !== want.zero_spread
                || got.last_out !== want.last_out)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result mismatch: exp norm %0d zero %0b last %0b, got norm %0d zero %0b last %0b",
                             want.norm_value, want.zero_spread, want.last_out,
                             got.norm_value, got.zero_spread, got.last_out);
            end
        endfunction

        function int pending();
            return expected_results.size();
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  sample_valid;
    logic                  sample_stall;
    sample_t               sample;
    logic                  result_valid;
    logic                  result_stall;
    result_t               result;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic                  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    zscore_scoreboard sb;
    int burst_left;
    bit gapless;
    int items_sent;
    int stall_cycle = 0;
    int stall_mode = 0;

    z_score_normalizer i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample       (sample),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #6 clk = ~clk;

    // receiver back-pressure in a randomly reshuffled mode
    always @(posedge clk)
    begin
        if (stall_cycle % 256 == 0)
            stall_mode = $urandom_range(0, 2);
        stall_cycle++;
        case (stall_mode)
            0: result_stall <= 1'b0;
            1: result_stall <= ($urandom_range(0, 3) == 0);
            default: result_stall <= ((stall_cycle % 16) < $urandom_range(0, 15));
        endcase
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
            sb.check_result(result);
    end

    task automatic send_sample(input logic cmd, input logic [15:0] value, input logic last);
        sample_t s;
        int gap;
        s.cmd          = cmd;
        s.sample_value = value;
        s.last_sample  = last;
        if (burst_left == 0)
        begin
            gapless    = ($urandom_range(0, 4) == 0);
            gap        = gapless ? 0 : $urandom_range(1, 7);
            burst_left = $urandom_range(1, 12);
            if (gap > 0)
            begin
                sample_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        sample_valid <= 1'b1;
        sample       <= s;
        @(posedge clk);
        while (sample_stall)
            @(posedge clk);
        sb.note_sample(s);
        items_sent++;
    endtask

    task automatic settle();
        sample_valid <= 1'b0;
        burst_left = 0;
        while (sb.pending() != 0)
            @(posedge clk);
        // statistics after a final load produce no beat; allow them to finish
        repeat (3000) @(posedge clk);
    endtask

    task automatic write_cfg(input logic idx, input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.write_reg(idx, data);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic load_set(input int count, input int style, input int early_reads);
        logic [15:0] base;
        logic [15:0] v;
        base = 16'($urandom);
        for (int i = 0; i < count; i++)
        begin
            case (style)
                0: v = 16'($urandom);
                1: v = 16'(base + $urandom_range(0, 255) - 128);
                2: v = base;
                default: v = $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
            endcase
            if (early_reads > 0 && $urandom_range(0, 3) == 0)
            begin
                send_sample(CMD_READ, 16'($urandom), 1'($urandom_range(0, 1)));
                early_reads--;
            end
            send_sample(CMD_LOAD, v, i == count - 1);
        end
    endtask

    task automatic read_n(input int count);
        for (int i = 0; i < count; i++)
            send_sample(CMD_READ, 16'($urandom), 1'($urandom_range(0, 1)));
    endtask

    initial
    begin
        int n;
        sb           = new();
        rst_n        = 1'b0;
        sample_valid = 1'b0;
        sample       = '0;
        cfg_valid    = 1'b0;
        cfg_index    = CFG_NUM_DIMS;
        cfg_data     = '0;
        burst_left   = 0;
        items_sent   = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: early read, range ends, excess read
        send_sample(CMD_READ, 16'h0000, 1'b0);
        send_sample(CMD_LOAD, 16'h7fff, 1'b0);
        send_sample(CMD_LOAD, 16'h8000, 1'b0);
        send_sample(CMD_LOAD, 16'h0001, 1'b0);
        send_sample(CMD_LOAD, 16'hffff, 1'b1);
        read_n(5);
        // zero deviation
        load_set(4, 2, 0);
        read_n(4);
        settle();
        // more dims than elements leaves empty dimensions
        write_cfg(CFG_NUM_DIMS, 4'd8);
        load_set(3, 3, 0);
        read_n(4);
        settle();
        write_cfg(CFG_ENABLE_WHITEN, 4'd0);
        write_cfg(CFG_NUM_DIMS, 4'd0);
        load_set(3, 0, 0);
        read_n(3);
        settle();

        while (items_sent < 600)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                settle();
                write_cfg(CFG_NUM_DIMS, CFG_DATA_W'($urandom_range(0, 15)));
                write_cfg(CFG_ENABLE_WHITEN, CFG_DATA_W'($urandom_range(0, 4) != 0));
            end
            n = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 20);
            load_set(n, $urandom_range(0, 3), $urandom_range(0, 1));
            if ($urandom_range(0, 9) == 0)
                read_n($urandom_range(0, n));
            else
                read_n(n + $urandom_range(0, 2));
        end

        settle();
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        #40000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

### files.f
hw/rtl/zsn_pkg.sv
hw/rtl/zsn_store.sv
hw/rtl/zsn_unit.sv
hw/rtl/z_score_normalizer.sv
dv/z_score_normalizer_tb.sv
